FILE: hw/rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the time ordered event queue
// Slot layout, cell operation codes, action and status codes.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OCC_W       = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [TIME_W-1:0] event_time;
    logic [KIND_W-1:0] event_kind;
    logic [TAG_W-1:0]  event_tag;
  } slot_t;

endpackage

FILE: hw/rtl/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell: one slot of the sorted shift queue
// Holds one event, compares its time with the incoming key and loads the
// new event or a neighbor's event as told.
// ----------------------------------------------------------------------------
module teq_cell (
  input  logic                        clk_i,
  input  teq_pkg::cell_op_e           op_i,
  input  teq_pkg::slot_t              new_i,
  input  teq_pkg::slot_t              left_i,
  input  teq_pkg::slot_t              right_i,
  output teq_pkg::slot_t              slot_o,
  output logic                        ge_o
);

  teq_pkg::slot_t slot_q, slot_d;

  // slot time at or above the key
  assign ge_o   = slot_q.event_time >= new_i.event_time;
  assign slot_o = slot_q;

  always_comb begin
    case (op_i)
      teq_pkg::CELL_HOLD:  slot_d = slot_q;
      teq_pkg::CELL_LOAD:  slot_d = new_i;
      teq_pkg::CELL_LEFT:  slot_d = left_i;
      teq_pkg::CELL_RIGHT: slot_d = right_i;
      default:             slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

FILE: hw/rtl/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue: bounded event queue sorted by event time
// A row of shift cells keeps events in ascending time order, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command word: insert
//   an event (time, kind, tag) or pop the earliest event. Output channel
//   (out_valid_o / out_stall_i) returns one result word per command: status,
//   the popped event (zero unless a pop succeeded) and the occupancy after
//   the command.
//   Every cell compares its time with the incoming time in parallel, so the
//   insert position is known in the same cycle; all cells then shift at once.
//   The result word is ready in the cycle after its command is accepted;
//   the block takes one command per cycle while the result channel does not
//   stall.
//   An insert into a full queue is dropped with status full; a pop on an
//   empty queue reports status empty and changes nothing.
//   Reset empties the queue (the count clears; cell contents are left as is)
//   and drops any pending result word.
//   While the receiver stalls, the result word holds and in_stall_o rises so
//   that no further command is taken until the word is delivered.
// ----------------------------------------------------------------------------
module time_ordered_event_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [teq_pkg::TIME_W-1:0]      event_time_i,
  input  logic [teq_pkg::KIND_W-1:0]      event_kind_i,
  input  logic [teq_pkg::TAG_W-1:0]       event_tag_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [teq_pkg::STATUS_W-1:0]    status_o,
  output logic [teq_pkg::TIME_W-1:0]      popped_time_o,
  output logic [teq_pkg::KIND_W-1:0]      popped_kind_o,
  output logic [teq_pkg::TAG_W-1:0]       popped_tag_o,
  output logic [teq_pkg::OCC_W-1:0]       occupancy_o
);

  localparam int unsigned Depth = teq_pkg::QUEUE_DEPTH;
  localparam int unsigned CntW  = teq_pkg::CNT_W;

  teq_pkg::slot_t    new_slot;
  teq_pkg::slot_t    slot_w [Depth];
  teq_pkg::cell_op_e op_w   [Depth];
  logic [Depth-1:0]  ge_w;
  logic [Depth-1:0]  hit_w;   // insert position at or below this cell

  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q;
  teq_pkg::status_e  status_q, status_d;
  teq_pkg::slot_t    popped_q, popped_d;
  logic [teq_pkg::OCC_W-1:0] occ_q;

  logic in_fire, is_insert, full, empty, do_insert, do_pop;

  // Take a new word whenever the result register is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign is_insert = action_i == teq_pkg::ACT_INSERT;
  assign full      = count_q == CntW'(Depth);
  assign empty     = count_q == '0;
  assign do_insert = in_fire && is_insert && !full;
  assign do_pop    = in_fire && !is_insert && !empty;

  assign new_slot.event_time = event_time_i;
  assign new_slot.event_kind = event_kind_i;
  assign new_slot.event_tag  = event_tag_i;

  // Head position: empty queue or time strictly below the head. Otherwise the
  // first held cell at or above the key, or the end of the held run.
  assign hit_w[0] = empty ||
                    (ge_w[0] && (slot_w[0].event_time != new_slot.event_time));

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic held;

    if (i > 0) begin : g_hit
      assign hit_w[i] = hit_w[0] || ge_w[i] || !held;
    end

    assign held = CntW'(i) < count_q;

    always_comb begin
      op_w[i] = teq_pkg::CELL_HOLD;
      if (do_insert && hit_w[i]) begin
        if (i == 0) begin
          op_w[i] = teq_pkg::CELL_LOAD;
        end else if (!hit_w[(i > 0) ? i - 1 : 0]) begin
          op_w[i] = teq_pkg::CELL_LOAD;
        end else begin
          op_w[i] = teq_pkg::CELL_LEFT;
        end
      end else if (do_pop && (i < Depth - 1)) begin
        op_w[i] = teq_pkg::CELL_RIGHT;
      end
    end

    teq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_w[i]),
      .new_i   (new_slot),
      .left_i  (slot_w[(i > 0) ? i - 1 : 0]),
      .right_i (slot_w[(i < Depth - 1) ? i + 1 : i]),
      .slot_o  (slot_w[i]),
      .ge_o    (ge_w[i])
    );
  end

  // Count and result word.
  always_comb begin
    count_d  = count_q;
    status_d = teq_pkg::STATUS_OK;
    popped_d = '0;
    if (do_insert) begin
      count_d = count_q + 1'b1;
    end
    if (do_pop) begin
      count_d  = count_q - 1'b1;
      popped_d = slot_w[0];
    end
    if (in_fire && is_insert && full) begin
      status_d = teq_pkg::STATUS_FULL;
    end
    if (in_fire && !is_insert && empty) begin
      status_d = teq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result word until delivered.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      popped_q <= popped_d;
      occ_q    <= teq_pkg::OCC_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign popped_time_o = popped_q.event_time;
  assign popped_kind_o = popped_q.event_kind;
  assign popped_tag_o  = popped_q.event_tag;
  assign occupancy_o   = occ_q;

endmodule

FILE: tb/time_ordered_event_queue_tb.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue_tb: self-checking bench for the sorted event queue
// Drives insert and pop command words with random bursts and gaps, stalls the
// result channel on its own random pattern, and checks every result word
// against a behavioral copy of the sorted queue kept inside the bench.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_tb;

  import teq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 16;

  // one expected result word, laid out like the output ports
  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] popped_time;
    logic [KIND_W-1:0] popped_kind;
    logic [TAG_W-1:0]  popped_tag;
    logic [OCC_W-1:0]  occupancy;
  } result_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                action_i;
  logic [TIME_W-1:0]   event_time_i;
  logic [KIND_W-1:0]   event_kind_i;
  logic [TAG_W-1:0]    event_tag_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [TIME_W-1:0]   popped_time_o;
  logic [KIND_W-1:0]   popped_kind_o;
  logic [TAG_W-1:0]    popped_tag_o;
  logic [OCC_W-1:0]    occupancy_o;

  // bench copy of the queue contents, head at index 0
  slot_t        held_events[$];
  // result words owed by the block, oldest first
  result_word_t results_due[$];

  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_pct    = 0;
  int unsigned stall_run    = 0;
  bit          stall_hold   = 1'b0;

  time_ordered_event_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .event_time_i  (event_time_i),
    .event_kind_i  (event_kind_i),
    .event_tag_i   (event_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_time_o (popped_time_o),
    .popped_kind_o (popped_kind_o),
    .popped_tag_o  (popped_tag_o),
    .occupancy_o   (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted command word to the bench queue and return the result
  // word the block owes for it. An event that is not below the head lands in
  // front of the first later slot whose time is at least its own, so an equal
  // time slips behind the head but ahead of equal times further back.
  function automatic result_word_t apply_event_command(
    logic              act,
    logic [TIME_W-1:0] t,
    logic [KIND_W-1:0] k,
    logic [TAG_W-1:0]  tg
  );
    result_word_t word;
    slot_t        entry;
    int unsigned  pos;
    word        = '0;
    word.status = STATUS_OK;
    if (act == ACT_INSERT) begin
      if (held_events.size() >= QUEUE_DEPTH) begin
        word.status = STATUS_FULL;
      end else begin
        pos = held_events.size();
        if (held_events.size() > 0 && t < held_events[0].event_time) begin
          pos = 0;
        end else begin
          for (int j = 1; j < held_events.size(); j++) begin
            if (held_events[j-1].event_time <= t && t <= held_events[j].event_time) begin
              pos = j;
              break;
            end
          end
        end
        entry.event_time = t;
        entry.event_kind = k;
        entry.event_tag  = tg;
        held_events.insert(pos, entry);
      end
    end else begin
      if (held_events.size() == 0) begin
        word.status = STATUS_EMPTY;
      end else begin
        entry            = held_events.pop_front();
        word.popped_time = entry.event_time;
        word.popped_kind = entry.event_kind;
        word.popped_tag  = entry.event_tag;
      end
    end
    word.occupancy = OCC_W'(held_events.size());
    return word;
  endfunction

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Predict on every accepted command word and check every delivered result
  // word in the same process, so that a same-edge push and pop cannot race.
  always @(posedge clk_i) begin : scoreboard
    result_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back(
          apply_event_command(action_i, event_time_i, event_kind_i, event_tag_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result word delivered with none outstanding");
          error_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status",      TIME_W'(want.status),      TIME_W'(status_o));
          check_field("popped_time", want.popped_time,          popped_time_o);
          check_field("popped_kind", TIME_W'(want.popped_kind), TIME_W'(popped_kind_o));
          check_field("popped_tag",  TIME_W'(want.popped_tag),  TIME_W'(popped_tag_o));
          check_field("occupancy",   TIME_W'(want.occupancy),   TIME_W'(occupancy_o));
        end
      end
    end
  end

  // Abort if neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: runs of stall or go, the stall share set by the
  // running test. A zero share gives a stretch with no stalls at all.
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_hold = ($urandom_range(0, 99) < stall_pct);
      stall_run  = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 6);
    end
    out_stall_i <= stall_hold;
    stall_run--;
  end

  // Present one command word and hold it until the block takes it.
  task automatic send_command(
    logic              act,
    logic [TIME_W-1:0] t,
    logic [KIND_W-1:0] k,
    logic [TAG_W-1:0]  tg
  );
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    action_i     <= act;
    event_time_i <= t;
    event_kind_i <= k;
    event_tag_i  <= tg;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid for a number of cycles; scramble the idle payload meanwhile.
  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      in_valid_i   <= 1'b0;
      action_i     <= 1'($urandom);
      event_time_i <= $urandom;
      event_kind_i <= 2'($urandom);
      event_tag_i  <= 16'($urandom);
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic test_empty_pop();
    stall_pct = 0;
    send_command(ACT_POP, '1, 2'd3, '1);
  endtask

  // Cover the time extremes, every kind including the unnamed one, tag
  // extremes, front insertion and equal times at the head and in the middle.
  task automatic test_insert_order();
    stall_pct = 0;
    send_command(ACT_INSERT, 32'd100,       2'd0, 16'h0000);
    send_command(ACT_INSERT, 32'hFFFF_FFFF, 2'd3, 16'hFFFF);
    send_command(ACT_INSERT, 32'd0,         2'd1, 16'h1234);
    send_command(ACT_INSERT, 32'd0,         2'd2, 16'h5555);
    send_command(ACT_INSERT, 32'd100,       2'd2, 16'hAAAA);
    send_command(ACT_INSERT, 32'd50,        2'd1, 16'h00FF);
    send_command(ACT_POP,    '0,            2'd0, '0);
    send_command(ACT_POP,    '0,            2'd0, '0);
  endtask

  // Four events remain from the order test: top the queue up to full under
  // back pressure, then push one more that would go to the front.
  task automatic test_full_queue();
    stall_pct = 50;
    for (int i = 0; i < QUEUE_DEPTH - 4; i++) begin
      send_command(ACT_INSERT, $urandom, 2'($urandom), 16'($urandom));
      idle_sender($urandom_range(0, 2));
    end
    send_command(ACT_INSERT, 32'd0, 2'd3, 16'hFFFF);
  endtask

  // Phases lean toward filling, draining or balance so the queue swings
  // between full and empty often; times cluster in a narrow band part of the
  // time to force equal-time placement.
  task automatic test_random_traffic(int unsigned total);
    int unsigned sent;
    int unsigned phase_left;
    int unsigned burst_left;
    int unsigned insert_pct;
    int unsigned gap_max;
    logic [TIME_W-1:0] t;
    logic              act;
    sent       = 0;
    phase_left = 0;
    burst_left = 0;
    insert_pct = 50;
    gap_max    = 0;
    while (sent < total) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 150);
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 4;
          default: gap_max = 12;
        endcase
      end
      if (burst_left == 0) begin
        idle_sender($urandom_range(0, gap_max));
        burst_left = $urandom_range(1, 16);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t = TIME_W'($urandom_range(0, 15));
        4:          t = $urandom_range(0, 1) ? '1 : '0;
        default:    t = $urandom;
      endcase
      act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_POP;
      send_command(act, t, 2'($urandom), 16'($urandom));
      sent++;
      phase_left--;
      burst_left--;
    end
  endtask

  // Release the result channel, wait for every owed word, let the block
  // settle, then report.
  task automatic finish_run();
    idle_sender(1);
    stall_pct = 0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_INSERT;
    event_time_i = '0;
    event_kind_i = '0;
    event_tag_i  = '0;
    out_stall_i  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_pop();
    test_insert_order();
    test_full_queue();
    test_random_traffic(1500);
    finish_run();
  end

endmodule
